@@ rtl/stbs_pkg.sv @@
`default_nettype none

package stbs_pkg;

    localparam int COUNT_W = 11;
    localparam int KEY_W   = 38;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] key_hash;
        logic [5:0]  key_track;
        logic [9:0]  load_index;
        logic [19:0] load_frames;
        logic [5:0]  load_flags;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [9:0]  entry_index;
        logic [19:0] frames;
        logic [5:0]  flags;
    } t_out_item;

    typedef struct packed {
        logic [31:0] hash;
        logic [5:0]  track;
        logic [19:0] frames;
        logic [5:0]  flags;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic write;     // load item taken
        logic start;     // lookup item taken
        logic probe;     // read entry at mid
        logic hit;       // capture matching entry
        logic step;      // narrow the window
        logic load_out;  // move result to output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic low_lt_high;
        logic key_eq;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/stbs_ram.sv @@
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/stbs_ctrl.sv @@
`default_nettype none

module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_mode,
    output logic      o_in_stall,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_LOAD) begin
                        o_cmd.write = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (i_sts.low_lt_high) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (i_sts.key_eq) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_DONE: begin
                // wait until the previous result has left the output register
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/stbs_dpath.sv @@
`default_nettype none

module stbs_dpath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_in_item           i_in_item,
    input  wire logic               i_cfg_valid,
    input  wire logic [COUNT_W-1:0] i_cfg_data,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output t_out_item               o_out_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0] r_count;
    logic [CW-1:0]      r_low;
    logic [CW-1:0]      r_high;
    logic [AW-1:0]      r_mid;
    logic [KEY_W-1:0]   r_key;
    t_out_item          r_res;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CW-1:0]      w_count_clamp;
    logic [CW:0]        w_sum;
    logic [CW-1:0]      w_mid;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_entry;
    t_entry             w_wentry;
    logic               w_we;
    logic               w_key_gt;

    assign w_count_clamp = (32'(r_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                              : CW'(r_count);
    assign w_sum   = {1'b0, r_low} + {1'b0, r_high};
    assign w_mid   = w_sum[CW:1];
    assign w_entry = t_entry'(w_rdata);

    assign w_wentry.hash   = i_in_item.key_hash;
    assign w_wentry.track  = i_in_item.key_track;
    assign w_wentry.frames = i_in_item.load_frames;
    assign w_wentry.flags  = i_in_item.load_flags;
    // loads beyond the table are dropped
    assign w_we = i_cmd.write && (32'(i_in_item.load_index) < 32'(TABLE_DEPTH));

    stbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in_item.load_index)),
        .i_wdata (w_wentry),
        .i_re    (i_cmd.probe),
        .i_raddr (w_mid[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_key_gt          = r_key > {w_entry.hash, w_entry.track};
    assign o_sts.key_eq      = r_key == {w_entry.hash, w_entry.track};
    assign o_sts.low_lt_high = r_low < r_high;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key  <= {i_in_item.key_hash, i_in_item.key_track};
            r_low  <= '0;
            r_high <= w_count_clamp;
            r_res  <= '0;
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid[AW-1:0];
        end
        if (i_cmd.step) begin
            if (w_key_gt) begin
                r_low <= CW'(r_mid) + CW'(1);
            end else begin
                r_high <= CW'(r_mid);
            end
        end
        if (i_cmd.hit) begin
            r_res.found       <= 1'b1;
            r_res.entry_index <= 10'(r_mid);
            r_res.frames      <= w_entry.frames;
            r_res.flags       <= w_entry.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ rtl/sorted_table_binary_search.sv @@
// Sorted key table with binary-search lookup. Entries (hash, track, frames, flags) are
// written by load items, one per cycle with no result; the first entry_count entries
// must be in ascending (hash, track) order for lookups to be meaningful. A lookup item
// searches them and gives one result: found, index, frames, flags (all zero on a miss).
// A lookup is entry (S_IDLE), then per probe one registered table read (S_CHK) and
// one compare (S_CMP), then hand-off (S_DONE); the input stalls until the result
// is moved to the output register, where it waits while the next item is taken.
// The user must write entry_count through the config channel only while idle; the
// block does not enforce it. Values above TABLE_DEPTH search the whole table.
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_item,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [COUNT_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_item.mode),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ rtl/stbs_checker.sv @@
`default_nettype none

module stbs_checker
    import stbs_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire t_in_item           i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire t_out_item          o_out_item,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready,
    input wire logic [COUNT_W-1:0] i_cfg_data
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // a lookup holds the input while it searches
    a_lookup_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.mode == MODE_LOOKUP) |=> o_in_stall)
        else $error("lookup item did not stall the input");

    // loads do not stall the input
    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.mode == MODE_LOAD) |=> !o_in_stall)
        else $error("load item stalled the input");

    // a new result only comes from a lookup in progress
    a_result_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a lookup in progress");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |->
            (o_out_item.entry_index == 10'd0 && o_out_item.frames == 20'd0 &&
             o_out_item.flags == 6'd0))
        else $error("miss result with nonzero fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result item changed");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

@@ dv/sorted_table_binary_search_checker.sv @@
module sorted_table_binary_search_checker
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire t_in_item           i_in_item,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire t_out_item          i_out_item,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [COUNT_W-1:0] i_cfg_data,
    input  wire logic               i_drain,
    output int                      o_pending,
    output int                      o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    t_entry             entry_table [TABLE_DEPTH];
    logic [COUNT_W-1:0] entry_count;
    t_out_item          lookup_results [$];
    int                 results_checked;
    bit                 drained;

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) entry_table[i] = '0;
        entry_count     = '0;
        results_checked = 0;
        drained         = 1'b0;
        o_pending       = 0;
        o_fail_count    = 0;
    end

    // binary search over the first entry_count entries, clipped to the table size
    function automatic t_out_item search_table(input logic [31:0] hash, input logic [5:0] track);
        t_out_item        res;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] probe_key;
        int               lo;
        int               hi;
        int               mid;
        res = '0;
        key = {hash, track};
        lo  = 0;
        hi  = int'(entry_count);
        if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
        while (lo < hi) begin
            mid       = (lo + hi) >> 1;
            probe_key = {entry_table[mid].hash, entry_table[mid].track};
            if (key == probe_key) begin
                res.found       = 1'b1;
                res.entry_index = mid[9:0];
                res.frames      = entry_table[mid].frames;
                res.flags       = entry_table[mid].flags;
                hi              = lo;
            end else if (key > probe_key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            entry_count = '0;
            lookup_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) entry_count = i_cfg_data;

            // results first: nothing accepted at this edge can already be on the output
            if (i_out_valid && !i_out_stall) begin
                if (lookup_results.size() == 0) begin
                    $display("%0t: result item with no lookup pending: found %0h index %0h",
                             $time, i_out_item.found, i_out_item.entry_index);
                    o_fail_count++;
                end else begin
                    want = lookup_results.pop_front();
                    if (i_out_item.found !== want.found) begin
                        $display("%0t: result %0d found: expected %0h, actual %0h",
                                 $time, results_checked, want.found, i_out_item.found);
                        o_fail_count++;
                    end
                    if (i_out_item.entry_index !== want.entry_index) begin
                        $display("%0t: result %0d entry_index: expected %0h, actual %0h",
                                 $time, results_checked, want.entry_index,
                                 i_out_item.entry_index);
                        o_fail_count++;
                    end
                    if (i_out_item.frames !== want.frames) begin
                        $display("%0t: result %0d frames: expected %0h, actual %0h",
                                 $time, results_checked, want.frames, i_out_item.frames);
                        o_fail_count++;
                    end
                    if (i_out_item.flags !== want.flags) begin
                        $display("%0t: result %0d flags: expected %0h, actual %0h",
                                 $time, results_checked, want.flags, i_out_item.flags);
                        o_fail_count++;
                    end
                end
                results_checked++;
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.mode == MODE_LOAD) begin
                    entry_table[i_in_item.load_index] = {i_in_item.key_hash, i_in_item.key_track,
                                                         i_in_item.load_frames,
                                                         i_in_item.load_flags};
                end else begin
                    lookup_results.push_back(search_table(i_in_item.key_hash,
                                                          i_in_item.key_track));
                end
            end

            if (i_drain && !drained) begin
                if (lookup_results.size() != 0) begin
                    $display("%0t: %0d lookup results never arrived", $time,
                             lookup_results.size());
                    o_fail_count += lookup_results.size();
                end
                drained = 1'b1;
            end
        end
        o_pending = lookup_results.size();
    end

endmodule

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int SETTLE      = 40;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_item           in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data  = '0;
    logic               drain     = 1'b0;
    int                 pending;
    int                 fail_count;

    logic [KEY_W-1:0] shadow_key [DEPTH];
    int send_pct      = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int loads_sent    = 0;
    int lookups_sent  = 0;
    int counts_set    = 0;
    int results_seen  = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sorted_table_binary_search DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    sorted_table_binary_search_checker #(
        .TABLE_DEPTH(DEPTH)
    ) search_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_drain     (drain),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall && rst_n) results_seen <= results_seen + 1;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic set_idling(input t_idling kind);
        case (kind)
            IDLE_NONE: begin
                send_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_pct  = 81;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_pct  = 0;
                stall_pct = 81;
            end
            default: begin
                send_pct  = 26;
                stall_pct = 26;
            end
        endcase
    endtask

    // valid stays high from one item to the next unless an idle cycle is drawn
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // loads give no result, so let any table write finish
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(input int value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= COUNT_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        counts_set++;
    endtask

    task automatic load_entry(input int idx, input logic [KEY_W-1:0] key,
                              input logic [19:0] frames, input logic [5:0] flags);
        t_in_item it;
        it.mode        = MODE_LOAD;
        it.key_hash    = key[KEY_W-1:6];
        it.key_track   = key[5:0];
        it.load_index  = 10'(idx);
        it.load_frames = frames;
        it.load_flags  = flags;
        shadow_key[idx] = key;
        send_item(it);
        loads_sent++;
    endtask

    // load fields carry junk on a lookup; the block must ignore them
    task automatic lookup(input logic [KEY_W-1:0] key);
        t_in_item it;
        it.mode        = MODE_LOOKUP;
        it.key_hash    = key[KEY_W-1:6];
        it.key_track   = key[5:0];
        it.load_index  = 10'($urandom());
        it.load_frames = 20'($urandom());
        it.load_flags  = 6'($urandom());
        send_item(it);
        lookups_sent++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int n);
        int r;
        int idx;
        r   = $urandom_range(0, 99);
        idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (n > 0 && r < 60) return shadow_key[idx];
        if (n > 0 && r < 75) return shadow_key[idx] + KEY_W'(1);
        if (n > 0 && r < 90) return shadow_key[idx] - KEY_W'(1);
        if (r < 95) return {$urandom(), 6'($urandom())};
        return r[0] ? KEY_MAX : '0;
    endfunction

    // fills entries 0..n-1 with ascending keys, loaded in shuffled order
    task automatic build_table(input int n, input bit span_ends, input bit dense);
        logic [KEY_W-1:0] keys [DEPTH];
        int               order [DEPTH];
        logic [63:0]      space;
        logic [63:0]      stride;
        logic [63:0]      cur;
        logic [63:0]      base;
        int               j;
        int               tmp;
        space  = dense ? (64'd1 << 14) : (64'd1 << KEY_W);
        stride = space / 64'(n + 1);
        cur    = {$urandom(), $urandom()} % (space - 64'(n) * stride);
        // dense tables share the upper 24 hash bits and differ in the low hash bits and track
        base   = dense ? {26'd0, $urandom() & 32'hFFFF_FF00, 6'd0} : 64'd0;
        for (int i = 0; i < n; i++) begin
            cur      = cur + 64'd1 + ({$urandom(), $urandom()} % stride);
            keys[i]  = KEY_W'(base + cur);
            order[i] = i;
        end
        if (span_ends) begin
            keys[0]     = '0;
            keys[n - 1] = KEY_MAX;
        end
        for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < n; i++) begin
            load_entry(order[i], keys[order[i]], 20'($urandom()), 6'($urandom()));
        end
    endtask

    task automatic run_lookups(input int count, input int tbl_n, input int num);
        int               span;
        int               idx;
        logic [KEY_W-1:0] key;
        span = (count > DEPTH) ? DEPTH : count;
        for (int i = 0; i < num; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                // rewrite a live entry; a fresh random key may break the ordering
                idx = $urandom_range(0, tbl_n - 1);
                key = $urandom_range(0, 1) ? shadow_key[idx] : {$urandom(), 6'($urandom())};
                load_entry(idx, key, 20'($urandom()), 6'($urandom()));
            end else begin
                lookup(pick_key(span));
            end
        end
    endtask

    initial begin
        int full_counts [4];
        int full_lookups [4];
        int n;
        int c;
        full_counts  = '{1024, 2047, 1025, 1023};
        full_lookups = '{100, 90, 60, 60};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty search window
        set_idling(IDLE_NONE);
        set_count(0);
        lookup('0);
        lookup(KEY_MAX);

        // tiny table at the key extremes
        load_entry(0, '0, 20'hFFFFF, 6'h3F);
        load_entry(1, {32'h8000_0000, 6'd5}, 20'h00000, 6'h00);
        load_entry(2, {32'hFFFF_FFFF, 6'd62}, 20'h55555, 6'h2A);
        load_entry(3, KEY_MAX, 20'hAAAAA, 6'h15);
        set_count(4);
        for (int i = 0; i < 4; i++) lookup(shadow_key[i]);
        lookup({32'h0000_0000, 6'd1});
        lookup({32'h8000_0000, 6'd4});
        lookup({32'h8000_0000, 6'd6});
        lookup({32'hFFFF_FFFF, 6'd61});
        lookup({32'h7FFF_FFFF, 6'd63});
        set_count(1);
        lookup(shadow_key[0]);
        lookup(KEY_MAX);

        // whole table, window below, at and beyond its size
        set_idling(IDLE_SENDER);
        build_table(DEPTH, 1'b1, 1'b0);
        for (int p = 0; p < 4; p++) begin
            set_idling(t_idling'((p + 1) % 4));
            set_count(full_counts[p]);
            run_lookups(full_counts[p], DEPTH, full_lookups[p]);
        end

        // small tables, sometimes searched only in part
        for (int p = 0; p < 8; p++) begin
            set_idling(t_idling'(p % 4));
            n = $urandom_range(1, 48);
            c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
            build_table(n, 1'b0, p[0]);
            set_count(c);
            run_lookups(c, n, 45);
        end

        wait_quiet();
        drain <= 1'b1;
        repeat (2) @(posedge clk);
        $display("run covered %0d load items and %0d lookups, %0d results compared",
                 loads_sent, lookups_sent, results_seen);
        $display("%0d entry_count settings from 0 to 2047, all four idling patterns",
                 counts_set);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
